@@ src/wbrm_pkg.sv @@
// Package for the windowed byte rate meter: field widths, packing widths
// and default window depth. No dependencies.
`timescale 1ns / 1ps

package wbrm_pkg;

  localparam int BYTE_W         = 32;
  localparam int TIME_W         = 24;
  localparam int FRAC_W         = 16;
  localparam int RATE_W         = 32;
  localparam int IN_W           = 2 * BYTE_W + TIME_W;
  localparam int OUT_W          = 2 * RATE_W;
  localparam int CNT_W          = $clog2(RATE_W);
  localparam int DEFAULT_WINDOW = 16;

endpackage

@@ src/windowed_byte_rate_meter.sv @@
// Windowed byte rate meter: ring of byte deltas and tick times, running
// window sums and one shared restoring divider. Depends on wbrm_pkg.
// When the time sum is zero the result needs no division; when both rates
// need the divider it runs two divisions of 32 one-bit steps each on the
// shared unit, after the ring read and update.
// A new transaction is accepted only when idle, once the previous result is in the output.
// Reset (rst, synchronous, active high) clears the ring valid bits, slot
// index, previous totals, window sums and output valid; no clearing pass.
`timescale 1ns / 1ps

module windowed_byte_rate_meter #(
  parameter int WINDOW = wbrm_pkg::DEFAULT_WINDOW
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        s_tvalid,
  output logic                        s_tready,
  // sent_total [31:0], received_total [63:32], tick_time [87:64]
  input  logic [wbrm_pkg::IN_W-1:0]   s_tdata,
  output logic                        m_tvalid,
  input  logic                        m_tready,
  // sent_rate [31:0], received_rate [63:32]
  output logic [wbrm_pkg::OUT_W-1:0]  m_tdata,
  // no_time [0]
  output logic [0:0]                  m_tuser
);

  import wbrm_pkg::*;

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int TSUM_W = TIME_W + $clog2(WINDOW + 1);
  localparam int SAT_W  = TSUM_W + FRAC_W;

  typedef enum logic [4:0] {
    S_IDLE   = 5'b00001,
    S_UPDATE = 5'b00010,
    S_CHECK  = 5'b00100,
    S_DIV    = 5'b01000,
    S_DONE   = 5'b10000
  } state_t;

  state_t              state;
  logic [SLOT_W-1:0]   slot;
  logic [WINDOW-1:0]   slot_valid;
  logic [BYTE_W-1:0]   previous_sent;
  logic [BYTE_W-1:0]   previous_received;
  logic [BYTE_W-1:0]   sum_sent;
  logic [BYTE_W-1:0]   sum_received;
  logic [TSUM_W-1:0]   sum_time;
  logic [BYTE_W-1:0]   delta_sent;
  logic [BYTE_W-1:0]   delta_received;
  logic [TIME_W-1:0]   tick;
  logic [IN_W-1:0]     ring [WINDOW];
  logic [IN_W-1:0]     ring_rd;
  logic                second;
  logic [TSUM_W-1:0]   rem;
  logic [BYTE_W-1:0]   dshift;
  logic [RATE_W-1:0]   quo;
  logic [CNT_W-1:0]    cnt;
  logic [RATE_W-1:0]   sent_rate;
  logic [RATE_W-1:0]   received_rate;
  logic                no_time;

  logic                accept;
  logic [BYTE_W-1:0]   old_sent;
  logic [BYTE_W-1:0]   old_received;
  logic [TIME_W-1:0]   old_tick;
  logic [BYTE_W-1:0]   bytes;
  logic [TSUM_W:0]     trial;
  logic                qbit;
  logic [TSUM_W-1:0]   rem_next;
  logic [RATE_W-1:0]   quo_next;

  assign s_tready = (state == S_IDLE);
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    if (slot_valid[slot]) begin
      old_sent     = ring_rd[BYTE_W-1:0];
      old_received = ring_rd[2*BYTE_W-1:BYTE_W];
      old_tick     = ring_rd[IN_W-1:2*BYTE_W];
    end else begin
      old_sent     = '0;
      old_received = '0;
      old_tick     = '0;
    end
    bytes    = second ? sum_received : sum_sent;
    trial    = {rem, dshift[BYTE_W-1]};
    qbit     = (trial >= {1'b0, sum_time});
    rem_next = qbit ? TSUM_W'(trial - {1'b0, sum_time}) : trial[TSUM_W-1:0];
    quo_next = {quo[RATE_W-2:0], qbit};
  end

  // Ring storage: read at the slot on accept, written in the update step.
  always_ff @(posedge clk) begin
    if (accept) begin
      ring_rd <= ring[slot];
    end
    if (state == S_UPDATE) begin
      ring[slot] <= {tick, delta_received, delta_sent};
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      delta_sent     <= s_tdata[BYTE_W-1:0] - previous_sent;
      delta_received <= s_tdata[2*BYTE_W-1:BYTE_W] - previous_received;
      tick           <= s_tdata[IN_W-1:2*BYTE_W];
    end
    case (state)
      S_CHECK: begin
        rem    <= TSUM_W'(bytes[BYTE_W-1:FRAC_W]);
        dshift <= {bytes[FRAC_W-1:0], {(BYTE_W-FRAC_W){1'b0}}};
        cnt    <= CNT_W'(RATE_W - 1);
      end
      S_DIV: begin
        rem    <= rem_next;
        dshift <= {dshift[BYTE_W-2:0], 1'b0};
        quo    <= quo_next;
        cnt    <= cnt - 1'b1;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      slot              <= '0;
      slot_valid        <= '0;
      previous_sent     <= '0;
      previous_received <= '0;
      sum_sent          <= '0;
      sum_received      <= '0;
      sum_time          <= '0;
      second            <= 1'b0;
      m_tvalid          <= 1'b0;
      m_tdata           <= '0;
      m_tuser           <= '0;
      sent_rate         <= '0;
      received_rate     <= '0;
      no_time           <= 1'b0;
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            previous_sent     <= s_tdata[BYTE_W-1:0];
            previous_received <= s_tdata[2*BYTE_W-1:BYTE_W];
            state             <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          sum_sent         <= sum_sent + delta_sent - old_sent;
          sum_received     <= sum_received + delta_received - old_received;
          sum_time         <= sum_time + TSUM_W'(tick) - TSUM_W'(old_tick);
          slot_valid[slot] <= 1'b1;
          slot             <= (slot == SLOT_W'(WINDOW - 1)) ? '0 : slot + 1'b1;
          second           <= 1'b0;
          state            <= S_CHECK;
        end
        S_CHECK: begin
          no_time <= (sum_time == '0);
          if (sum_time == '0 || SAT_W'(bytes) >= {sum_time, {FRAC_W{1'b0}}}) begin
            if (second) begin
              received_rate <= (sum_time == '0) ? '0 : '1;
              state         <= S_DONE;
            end else begin
              sent_rate <= (sum_time == '0) ? '0 : '1;
              second    <= 1'b1;
            end
          end else begin
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == '0) begin
            if (second) begin
              received_rate <= quo_next;
              state         <= S_DONE;
            end else begin
              sent_rate <= quo_next;
              second    <= 1'b1;
              state     <= S_CHECK;
            end
          end
        end
        S_DONE: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {received_rate, sent_rate};
            m_tuser  <= no_time;
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule
